// File: rtl/core/kbucket_contact_admission_core_assert.svh
// Assertion macros for the contact admission core and its checker
`ifndef KBUCKET_CONTACT_ADMISSION_CORE_ASSERT_SVH
`define KBUCKET_CONTACT_ADMISSION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define KBCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define KBCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/kbca_pkg.sv
// Types and constants of the contact admission core
package kbca_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int ENTRY_W    = 176;

  localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;

  localparam logic [5:0] BIN_SUBNET_RST    = 6'd2;
  localparam logic [7:0] GLOBAL_SUBNET_RST = 8'd10;
  localparam logic [3:0] GLOBAL_IP_RST     = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_SUBNET    = 2'd0,
    REG_GLOBAL_SUBNET = 2'd1,
    REG_GLOBAL_IP     = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ALIVE  = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_IP       = 3'd2,
    STAT_GSUB     = 3'd3,
    STAT_BSUB     = 3'd4,
    STAT_FULL     = 3'd5,
    STAT_NOTFOUND = 3'd6,
    STAT_SAME     = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SH_RD,
    ST_SH_WR,
    ST_TAIL,
    ST_FIN,
    ST_RESP
  } state_t;

endpackage

// File: rtl/core/kbca_if.sv
// Request and response channel interfaces of the contact admission core
interface kbca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  bucket;
  logic [63:0] id_high;
  logic [63:0] id_low;
  logic [31:0] address;
  logic [15:0] udp_port;
  logic        is_lan;

  modport source (output valid, command, bucket, id_high, id_low, address, udp_port, is_lan,
                  input ready);
  modport sink (input valid, command, bucket, id_high, id_low, address, udp_port, is_lan,
                output ready);
endinterface

interface kbca_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] status;
  logic [3:0] occupancy;

  modport source (output valid, accepted, status, occupancy, input ready);
  modport sink (input valid, accepted, status, occupancy, output ready);
endinterface

// File: rtl/core/kbucket_contact_admission_core.sv
// Contact admission core: k-bucket slot memory, scan sequencer and limit checks
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | command, bucket, id_high, id_low, address, udp_port, is_lan
//   rsp     | out | valid / ready | accepted, status, occupancy
//   cfg     | in  | cfg_write     | cfg_index, cfg_data
//
// One item at a time. A command scans every slot through the single read port of the
// slot memory; mark-alive and remove then shift each later entry of the bucket down by
// one slot, with a read state and a write state per entry, then the result waits in rsp.
// A bad bucket index skips the scan. req.ready is high only while idle.
// Synchronous reset empties every bucket and restores the limit registers.
module kbucket_contact_admission_core #(
  parameter int BUCKET_SIZE = 10,
  parameter int NUM_BUCKETS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kbca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbca_pkg::CFG_DATA_W-1:0] cfg_data,
  kbca_req_if.sink                       req,
  kbca_rsp_if.source                     rsp
);
  import kbca_pkg::*;

  localparam int SLOT_COUNT = NUM_BUCKETS * BUCKET_SIZE;
  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int PW   = $clog2(BUCKET_SIZE);
  localparam int FW   = $clog2(BUCKET_SIZE + 1);
  localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int CMPW = CW + 8;

  state_t state, state_next;

  // limits
  logic [5:0] bin_lim;
  logic [7:0] gsub_lim;
  logic [3:0] ip_lim;

  // latched command
  cmd_t        c_cmd;
  logic [3:0]  c_bucket;
  logic [63:0] c_hi, c_lo;
  logic [31:0] c_addr;
  logic [15:0] c_port;
  logic        c_lan;
  logic [BW-1:0] c_idx;
  logic [BW+3:0] c_ext;

  // bucket fill
  logic [FW-1:0] fill [NUM_BUCKETS];
  logic [FW-1:0] fill_rd, cur_fill;
  logic [BW-1:0] fill_sel;

  // slot memory
  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [SW-1:0]      raddr, waddr;
  logic               we;

  // scan
  logic [BW-1:0] sb;
  logic [PW-1:0] sp;
  logic [SW-1:0] scan_slot, base;
  logic          rd_live, rd_own;
  logic [SW-1:0] rd_slot;
  logic [PW-1:0] rd_pos;
  logic [CW-1:0] ip_cnt, gsub_cnt, bsub_cnt;
  logic          found;
  logic [PW-1:0] pos;
  logic [SW-1:0] hit_slot;
  logic [31:0]   old_addr;
  logic [15:0]   old_port;

  logic [PW-1:0] sh_i;
  status_t       stat, dec_stat;

  logic id_hit, ip_hit, sub_hit, scan_last, shift_more, start_more, sub_changed;
  logic bucket_bad;

  assign c_ext      = {{BW{1'b0}}, c_bucket};
  assign c_idx      = c_ext[BW-1:0];
  assign bucket_bad = c_ext >= (BW+4)'(NUM_BUCKETS);
  assign fill_sel   = (state == ST_SCAN) ? sb : c_idx;
  assign fill_rd    = fill[fill_sel];
  assign scan_last  = scan_slot == SW'(SLOT_COUNT - 1);

  assign id_hit  = rd_own && rdata[175:112] == c_hi && rdata[111:48] == c_lo;
  assign ip_hit  = rdata[47:16] == c_addr;
  assign sub_hit = (rdata[47:16] & SUBNET_MASK) == (c_addr & SUBNET_MASK);

  assign sub_changed = (old_addr & SUBNET_MASK) != (c_addr & SUBNET_MASK);
  assign start_more  = ((FW+1)'(pos) + (FW+1)'(1)) < (FW+1)'(cur_fill);
  assign shift_more  = ((FW+1)'(sh_i) + (FW+1)'(2)) < (FW+1)'(cur_fill);

  // admission checks
  always_comb begin
    dec_stat = STAT_OK;
    unique case (c_cmd)
      CMD_ADD: begin
        priority if (found) dec_stat = STAT_DUP;
        else if (CMPW'(ip_cnt) >= CMPW'(ip_lim)) dec_stat = STAT_IP;
        else if (!c_lan && CMPW'(gsub_cnt) >= CMPW'(gsub_lim)) dec_stat = STAT_GSUB;
        else if (!c_lan && CMPW'(bsub_cnt) >= CMPW'(bin_lim)) dec_stat = STAT_BSUB;
        else if ((FW+1)'(cur_fill) >= (FW+1)'(BUCKET_SIZE)) dec_stat = STAT_FULL;
        else dec_stat = STAT_OK;
      end
      CMD_CHANGE: begin
        priority if (!found) dec_stat = STAT_NOTFOUND;
        else if (old_addr == c_addr) dec_stat = STAT_SAME;
        else if (CMPW'(ip_cnt) >= CMPW'(ip_lim)) dec_stat = STAT_IP;
        else if (sub_changed && !c_lan && CMPW'(gsub_cnt) >= CMPW'(gsub_lim))
          dec_stat = STAT_GSUB;
        else if (sub_changed && !c_lan && CMPW'(bsub_cnt) >= CMPW'(bin_lim))
          dec_stat = STAT_BSUB;
        else dec_stat = STAT_OK;
      end
      CMD_ALIVE, CMD_REMOVE: dec_stat = found ? STAT_OK : STAT_NOTFOUND;
      default: dec_stat = STAT_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = base + SW'(cur_fill);
    wdata = {c_hi, c_lo, c_addr, c_port};
    raddr = scan_slot;
    unique case (state)
      ST_IDLE:  if (req.valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = bucket_bad ? ST_RESP : ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DECIDE;
      ST_DECIDE: begin
        state_next = ST_RESP;
        if (dec_stat == STAT_OK) begin
          unique case (c_cmd)
            CMD_ADD: we = 1'b1;
            CMD_CHANGE: begin
              we    = 1'b1;
              waddr = hit_slot;
              wdata = {c_hi, c_lo, c_addr, old_port};
            end
            CMD_ALIVE:  state_next = start_more ? ST_SH_RD : ST_TAIL;
            CMD_REMOVE: state_next = start_more ? ST_SH_RD : ST_FIN;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SH_RD: begin
        raddr      = base + SW'(sh_i) + SW'(1);
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        we    = 1'b1;
        waddr = base + SW'(sh_i);
        wdata = rdata;
        if (shift_more) state_next = ST_SH_RD;
        else state_next = (c_cmd == CMD_ALIVE) ? ST_TAIL : ST_FIN;
      end
      ST_TAIL: begin
        we    = 1'b1;
        waddr = base + SW'(cur_fill) - SW'(1);
        wdata = {c_hi, c_lo, old_addr, old_port};
        state_next = ST_RESP;
      end
      ST_FIN:  state_next = ST_RESP;
      ST_RESP: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_lim  <= BIN_SUBNET_RST;
      gsub_lim <= GLOBAL_SUBNET_RST;
      ip_lim   <= GLOBAL_IP_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BIN_SUBNET:    bin_lim  <= cfg_data[5:0];
        REG_GLOBAL_SUBNET: gsub_lim <= cfg_data[7:0];
        REG_GLOBAL_IP:     ip_lim   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUCKETS; b++) fill[b] <= '0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= (state == ST_SCAN) && (FW'(sp) < fill_rd);
      if (state == ST_DECIDE && c_cmd == CMD_ADD && dec_stat == STAT_OK)
        fill[c_idx] <= cur_fill + FW'(1);
      if (state == ST_FIN)
        fill[c_idx] <= cur_fill - FW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        c_cmd    <= cmd_t'(req.command);
        c_bucket <= req.bucket;
        c_hi     <= req.id_high;
        c_lo     <= req.id_low;
        c_addr   <= req.address;
        c_port   <= req.udp_port;
        c_lan    <= req.is_lan;
      end
      ST_LOAD: begin
        cur_fill  <= bucket_bad ? '0 : fill_rd;
        stat      <= STAT_NOTFOUND;
        sb        <= '0;
        sp        <= '0;
        scan_slot <= '0;
        base      <= '0;
        ip_cnt    <= '0;
        gsub_cnt  <= '0;
        bsub_cnt  <= '0;
        found     <= 1'b0;
      end
      default: ;
    endcase

    if (state == ST_SCAN) begin
      rd_own  <= sb == c_idx;
      rd_slot <= scan_slot;
      rd_pos  <= sp;
      if (sb == c_idx && sp == '0) base <= scan_slot;
      scan_slot <= scan_slot + SW'(1);
      if (sp == PW'(BUCKET_SIZE - 1)) begin
        sp <= '0;
        sb <= sb + BW'(1);
      end else begin
        sp <= sp + PW'(1);
      end
    end

    // compare stage, one slot behind the read address
    if (rd_live) begin
      if (ip_hit) ip_cnt <= ip_cnt + CW'(1);
      if (sub_hit) gsub_cnt <= gsub_cnt + CW'(1);
      if (sub_hit && rd_own) bsub_cnt <= bsub_cnt + CW'(1);
      if (id_hit && !found) begin
        found    <= 1'b1;
        pos      <= rd_pos;
        hit_slot <= rd_slot;
        old_addr <= rdata[47:16];
        old_port <= rdata[15:0];
      end
    end

    if (state == ST_DECIDE) begin
      stat <= dec_stat;
      sh_i <= pos;
      if (c_cmd == CMD_ADD && dec_stat == STAT_OK) cur_fill <= cur_fill + FW'(1);
    end
    if (state == ST_SH_WR) sh_i <= sh_i + PW'(1);
    if (state == ST_FIN) cur_fill <= cur_fill - FW'(1);
  end

  logic [FW+3:0] occ_ext;
  assign occ_ext = {4'd0, cur_fill};

  assign req.ready     = state == ST_IDLE;
  assign rsp.valid     = state == ST_RESP;
  assign rsp.status    = stat;
  assign rsp.accepted  = (stat == STAT_OK) || (stat == STAT_SAME);
  assign rsp.occupancy = occ_ext[3:0];

endmodule

// File: rtl/core/kbca_checker.sv
// Port-level checker for the contact admission core, bound to the top level
module kbca_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [2:0] out_status
);
  import kbca_pkg::*;

  `include "kbucket_contact_admission_core_assert.svh"

  `KBCA_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid)
  `KBCA_ASSERT_NOW(a_one_at_a_time, out_valid, !in_ready)
  `KBCA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !out_valid)
  `KBCA_ASSERT_NOW(a_accept_code, out_valid,
                   out_accepted == (out_status == STAT_OK || out_status == STAT_SAME))

endmodule

bind kbucket_contact_admission_core kbca_checker u_kbca_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .out_accepted (rsp.accepted),
  .out_status   (rsp.status)
);

// File: tb/sv/tb.sv
// Testbench for the contact admission core: directed and random commands checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kbca_pkg::*;

  localparam int NB = 16;
  localparam int BS = 10;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  bucket;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] address;
    logic [15:0] udp_port;
    logic        is_lan;
  } contact_cmd_t;

  typedef struct packed {
    logic       accepted;
    status_t    status;
    logic [3:0] occupancy;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kbca_req_if req ();
  kbca_rsp_if rsp ();

  kbucket_contact_admission_core #(.BUCKET_SIZE(BS), .NUM_BUCKETS(NB)) i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always #2 clk = ~clk;

  // shadow of the bucket table
  logic [63:0] sh_id_high [NB*BS];
  logic [63:0] sh_id_low [NB*BS];
  logic [31:0] sh_addr [NB*BS];
  logic [15:0] sh_port [NB*BS];
  int unsigned sh_fill [NB];
  logic [5:0] lim_bin = BIN_SUBNET_RST;
  logic [7:0] lim_gsub = GLOBAL_SUBNET_RST;
  logic [3:0] lim_ip = GLOBAL_IP_RST;

  verdict_t pending_verdicts [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [23:0] subnet_pool [8];

  initial begin
    req.valid = 1'b0;
    req.command = CMD_ADD;
    req.bucket = '0;
    req.id_high = '0;
    req.id_low = '0;
    req.address = '0;
    req.udp_port = '0;
    req.is_lan = 1'b0;
    rsp.ready = 1'b0;
    foreach (sh_fill[i]) sh_fill[i] = 0;
  end

  function automatic int unsigned count_global(logic [31:0] a, logic [31:0] mask);
    int unsigned n = 0;
    for (int b = 0; b < NB; b++)
      for (int i = 0; i < sh_fill[b]; i++)
        if ((sh_addr[b*BS+i] & mask) == (a & mask)) n++;
    return n;
  endfunction

  function automatic int unsigned count_bucket_subnet(int b, logic [31:0] a);
    int unsigned n = 0;
    for (int i = 0; i < sh_fill[b]; i++)
      if ((sh_addr[b*BS+i] & SUBNET_MASK) == (a & SUBNET_MASK)) n++;
    return n;
  endfunction

  function automatic int find_contact(int b, logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < sh_fill[b]; i++)
      if (sh_id_high[b*BS+i] == hi && sh_id_low[b*BS+i] == lo) return i;
    return BS;
  endfunction

  function automatic void drop_slot(int b, int pos);
    for (int i = pos; i + 1 < sh_fill[b]; i++) begin
      sh_id_high[b*BS+i] = sh_id_high[b*BS+i+1];
      sh_id_low[b*BS+i] = sh_id_low[b*BS+i+1];
      sh_addr[b*BS+i] = sh_addr[b*BS+i+1];
      sh_port[b*BS+i] = sh_port[b*BS+i+1];
    end
    sh_fill[b]--;
  endfunction

  function automatic verdict_t admit_contact(contact_cmd_t c);
    verdict_t v;
    int b, pos, s;
    logic [63:0] th, tl;
    logic [31:0] ta, old;
    logic [15:0] tp;
    logic new_subnet;
    status_t st = STAT_OK;
    b = c.bucket;
    pos = find_contact(b, c.id_high, c.id_low);
    if (c.command == CMD_ADD) begin
      if (pos < BS) st = STAT_DUP;
      else if (count_global(c.address, '1) >= lim_ip) st = STAT_IP;
      else if (!c.is_lan && count_global(c.address, SUBNET_MASK) >= lim_gsub) st = STAT_GSUB;
      else if (!c.is_lan && count_bucket_subnet(b, c.address) >= lim_bin) st = STAT_BSUB;
      else if (sh_fill[b] >= BS) st = STAT_FULL;
      else begin
        s = b*BS + sh_fill[b];
        sh_id_high[s] = c.id_high;
        sh_id_low[s] = c.id_low;
        sh_addr[s] = c.address;
        sh_port[s] = c.udp_port;
        sh_fill[b]++;
      end
    end else if (pos >= BS) begin
      st = STAT_NOTFOUND;
    end else if (c.command == CMD_ALIVE) begin
      s = b*BS + pos;
      th = sh_id_high[s]; tl = sh_id_low[s]; ta = sh_addr[s]; tp = sh_port[s];
      drop_slot(b, pos);
      s = b*BS + sh_fill[b];
      sh_id_high[s] = th; sh_id_low[s] = tl; sh_addr[s] = ta; sh_port[s] = tp;
      sh_fill[b]++;
    end else if (c.command == CMD_CHANGE) begin
      s = b*BS + pos;
      old = sh_addr[s];
      new_subnet = (old & SUBNET_MASK) != (c.address & SUBNET_MASK);
      if (old == c.address) st = STAT_SAME;
      else if (count_global(c.address, '1) >= lim_ip) st = STAT_IP;
      else if (new_subnet && !c.is_lan && count_global(c.address, SUBNET_MASK) >= lim_gsub)
        st = STAT_GSUB;
      else if (new_subnet && !c.is_lan && count_bucket_subnet(b, c.address) >= lim_bin)
        st = STAT_BSUB;
      else sh_addr[s] = c.address;
    end else begin
      drop_slot(b, pos);
    end
    v.accepted = (st == STAT_OK || st == STAT_SAME);
    v.status = st;
    v.occupancy = sh_fill[b][3:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // response side: random stall and compare
  always @(posedge clk) begin
    verdict_t w;
    rsp.ready <= ($urandom_range(99) >= recv_idle);
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        w = pending_verdicts.pop_front();
        if (rsp.accepted !== w.accepted) report_mismatch("accepted", rsp.accepted, w.accepted);
        if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
        if (rsp.occupancy !== w.occupancy)
          report_mismatch("occupancy", rsp.occupancy, w.occupancy);
      end
    end
  end

  task automatic send_item(contact_cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= c.command;
    req.bucket <= c.bucket;
    req.id_high <= c.id_high;
    req.id_low <= c.id_low;
    req.address <= c.address;
    req.udp_port <= c.udp_port;
    req.is_lan <= c.is_lan;
    do @(posedge clk); while (!req.ready);
    pending_verdicts.insert(pending_verdicts.size(), admit_contact(c));
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [5:0] bin, logic [7:0] gsub, logic [3:0] ip);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_BIN_SUBNET;
    cfg_data <= bin;
    @(posedge clk);
    cfg_index <= REG_GLOBAL_SUBNET;
    cfg_data <= gsub;
    @(posedge clk);
    cfg_index <= REG_GLOBAL_IP;
    cfg_data <= ip;
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_bin = bin;
    lim_gsub = gsub;
    lim_ip = ip;
  endtask

  function automatic contact_cmd_t mk(cmd_t op, int b, logic [63:0] hi, logic [63:0] lo,
                                      logic [31:0] a, logic [15:0] p, logic lan);
    contact_cmd_t c;
    c.command = op; c.bucket = 4'(b); c.id_high = hi; c.id_low = lo;
    c.address = a; c.udp_port = p; c.is_lan = lan;
    return c;
  endfunction

  task automatic test_add_checks;
    // reset limits: one per IP, two per /24 in a bucket
    send_item(mk(CMD_ADD, 0, 64'd1, 64'd1, 32'h0A000001, 16'd1, 0));
    send_item(mk(CMD_ADD, 0, 64'd1, 64'd1, 32'h0A000009, 16'd1, 0));   // duplicate id
    send_item(mk(CMD_ADD, 0, 64'd2, 64'd2, 32'h0A000001, 16'd1, 0));   // same IP
    send_item(mk(CMD_ADD, 0, 64'd3, 64'd3, 32'h0A000002, 16'd2, 0));
    send_item(mk(CMD_ADD, 0, 64'd4, 64'd4, 32'h0A000003, 16'd3, 0));   // bucket /24 full
    send_item(mk(CMD_ADD, 0, 64'd4, 64'd4, 32'h0A000003, 16'd3, 1));   // lan waives it
    send_item(mk(CMD_ADD, 5, 64'd1, 64'd1, 32'h0A000004, 16'd3, 0));   // same id, other bucket
    send_item(mk(CMD_ADD, 15, '1, '1, '1, '1, 1));
    send_item(mk(CMD_ADD, 15, '0, '0, '0, '0, 0));
    for (int i = 0; i < 7; i++)
      send_item(mk(CMD_ADD, 0, 64'd10 + i, 64'd0, 32'h14000000 + (i << 8), 16'(i), 0));
    send_item(mk(CMD_ADD, 0, 64'd99, 64'd0, 32'h1E000000, 16'd0, 0));  // bucket full
  endtask

  task automatic test_update_remove;
    send_item(mk(CMD_ALIVE, 0, 64'd1, 64'd1, '0, '0, 0));
    send_item(mk(CMD_ALIVE, 0, 64'd77, 64'd1, '0, '0, 0));             // unknown id
    send_item(mk(CMD_CHANGE, 0, 64'd3, 64'd3, 32'h0A000002, '0, 0));    // unchanged
    send_item(mk(CMD_CHANGE, 0, 64'd3, 64'd3, 32'h0A000001, '0, 0));    // IP taken
    send_item(mk(CMD_CHANGE, 0, 64'd3, 64'd3, 32'h0A000007, '0, 0));    // same /24
    send_item(mk(CMD_CHANGE, 0, 64'd3, 64'd3, 32'h14000001, '0, 0));    // other /24, still within limits
    send_item(mk(CMD_CHANGE, 0, 64'd55, 64'd3, 32'h14000001, '0, 0));   // unknown id
    send_item(mk(CMD_REMOVE, 0, 64'd1, 64'd1, '0, '0, 0));
    send_item(mk(CMD_REMOVE, 0, 64'd1, 64'd1, '0, '0, 0));             // already gone
  endtask

  task automatic test_limit_extremes;
    set_limits(6'd0, 8'd0, 4'd0);          // zero limits reject everything they reach
    send_item(mk(CMD_ADD, 3, 64'd5, 64'd5, 32'h28000001, 16'd5, 1));
    set_limits(6'd32, 8'd0, 4'd15);
    send_item(mk(CMD_ADD, 3, 64'd5, 64'd5, 32'h28000001, 16'd5, 0));
    send_item(mk(CMD_ADD, 3, 64'd5, 64'd5, 32'h28000001, 16'd5, 1));
    set_limits(6'd1, 8'd1, 4'd1);
    send_item(mk(CMD_ADD, 4, 64'd6, 64'd6, 32'h28000002, 16'd6, 0));
    set_limits(6'd63, 8'd255, 4'd15);
  endtask

  function automatic contact_cmd_t random_cmd;
    contact_cmd_t c;
    int b, r, pos;
    r = $urandom_range(99);
    c.command = (r < 45) ? CMD_ADD : (r < 65) ? CMD_ALIVE : (r < 85) ? CMD_CHANGE : CMD_REMOVE;
    b = ($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(NB-1);
    c.bucket = 4'(b);
    c.id_high = {$urandom, $urandom};
    c.id_low = {$urandom, $urandom};
    if ($urandom_range(99) < 85)
      c.address = {subnet_pool[$urandom_range(7)], 6'd0, 2'($urandom_range(3))};
    else
      c.address = $urandom;
    c.udp_port = 16'($urandom);
    c.is_lan = ($urandom_range(99) < 30);
    // address a contact that is present: mostly, but rarely for an add
    if (sh_fill[b] != 0 && $urandom_range(99) < ((c.command == CMD_ADD) ? 10 : 85)) begin
      pos = $urandom_range(sh_fill[b] - 1);
      c.id_high = sh_id_high[b*BS+pos];
      c.id_low = sh_id_low[b*BS+pos];
      if (c.command == CMD_CHANGE && $urandom_range(9) == 0) c.address = sh_addr[b*BS+pos];
    end
    return c;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 99)
        set_limits(6'($urandom_range(32, 1)), 8'($urandom_range(255, 1)),
                   4'($urandom_range(15, 1)));
      if (i == 50) drain();   // let the block run dry once before sending on
      send_item(random_cmd());
    end
  endtask

  initial begin
    timeout_guard: begin end
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    foreach (subnet_pool[i]) subnet_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle = 28;
    recv_idle = 76;
    test_add_checks();
    test_update_remove();
    test_limit_extremes();
    test_random(260);
    send_idle = 76;
    recv_idle = 28;
    test_random(260);
    send_idle = 0;
    recv_idle = 0;
    test_random(260);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: kbucket_contact_admission_core.f
+incdir+rtl/core
rtl/core/kbca_pkg.sv
rtl/core/kbca_if.sv
rtl/core/kbucket_contact_admission_core.sv
rtl/core/kbca_checker.sv
tb/sv/tb.sv
